// ===== rtl/batch_frame_checker_parser_top_assert.svh =====
// Assertion macros shared by the checker/parser RTL.
// No dependencies; define ASSERT_OFF to compile them out.
`ifndef BATCH_FRAME_CHECKER_PARSER_TOP_ASSERT_SVH
`define BATCH_FRAME_CHECKER_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFCP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define BFCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFCP_ASSERT(lbl, clk, rstn, prop)
`define BFCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/bfcp_pkg.sv =====
// Shared types and constants for the sealed batch-frame checker/parser.
// No dependencies.
package bfcp_pkg;

    localparam int unsigned MAX_TOKENS_DEF  = 4096;
    localparam int unsigned MAX_SEQ_IDS_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [63:0] HASH_SEED_RST = 64'hcbf29ce484222325;
    // FNV prime is 2^40 + 0x1b3; the multiply is done as shift-adds
    localparam logic [63:0] FNV_PRIME     = 64'h0000_0100_0000_01b3;

    localparam int unsigned PRESENT_POS = 0;
    localparam int unsigned PRESENT_SEQ = 1;
    localparam int unsigned PRESENT_LOG = 2;
    localparam logic [7:0]  PRESENT_MAX = 8'd7;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_CHECKSUM    = 4'd2,
        ST_TRUNC_HDR   = 4'd3,
        ST_BAD_HEADER  = 4'd4,
        ST_TRUNC_TOK   = 4'd5,
        ST_TRUNC_POS   = 4'd6,
        ST_TRUNC_CNT   = 4'd7,
        ST_NEGATIVE    = 4'd8,
        ST_SUM         = 4'd9,
        ST_TRUNC_IDS   = 4'd10,
        ST_TRUNC_LOG   = 4'd11,
        ST_TRAILING    = 4'd12
    } status_t;

    typedef enum logic [2:0] {
        EK_TOKEN = 3'd0,
        EK_POS   = 3'd1,
        EK_COUNT = 3'd2,
        EK_SEQID = 3'd3,
        EK_LOGIT = 3'd4
    } elem_kind_t;

    // one queue entry: what the front learned about an accepted beat
    typedef struct packed {
        logic       body;
        logic [7:0] data;
        logic       last;
        logic       short_frame;
        logic       csum_bad;
    } ev_t;

    typedef struct packed {
        logic               is_verdict;
        logic [3:0]         status;
        logic [2:0]         elem_kind;
        logic [15:0]        elem_index;
        logic signed [31:0] elem_value;
        logic [31:0]        seq_number;
        logic               encode_kind;
        logic               has_positions;
        logic               has_sequences;
        logic               has_logits;
        logic [12:0]        token_count;
        logic [16:0]        seq_id_total;
    } res_t;

endpackage

// ===== rtl/bfcp_if.sv =====
// Channel interfaces: frame bytes in, results out, seed configuration.
// No dependencies.
interface bfcp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface bfcp_result_if;
    logic               valid;
    logic               ready;
    logic               is_verdict;
    logic [3:0]         status;
    logic [2:0]         elem_kind;
    logic [15:0]        elem_index;
    logic signed [31:0] elem_value;
    logic [31:0]        seq_number;
    logic               encode_kind;
    logic               has_positions;
    logic               has_sequences;
    logic               has_logits;
    logic [12:0]        token_count;
    logic [16:0]        seq_id_total;
    modport source (output valid, is_verdict, status, elem_kind, elem_index, elem_value,
                    seq_number, encode_kind, has_positions, has_sequences, has_logits,
                    token_count, seq_id_total, input ready);
    modport sink   (input valid, is_verdict, status, elem_kind, elem_index, elem_value,
                    seq_number, encode_kind, has_positions, has_sequences, has_logits,
                    token_count, seq_id_total, output ready);
endinterface

interface bfcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_seed;
    modport source (output valid, hash_seed, input ready);
    modport sink   (input valid, hash_seed, output ready);
endinterface

// ===== rtl/bfcp_front.sv =====
// Front end: check-byte delay line, FNV-1a-64 hash and seed register.
// Depends on bfcp_pkg and bfcp_if.
module bfcp_front
    import bfcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bfcp_cfg_if.sink      cfg,
    bfcp_frame_if.sink    frame,
    output ev_t           ev,
    output logic          ev_push,
    input  logic          q_full
);

    logic [63:0]      seed_reg;
    logic [63:0]      hash_reg;
    logic [63:0]      hash_next;
    logic [3:0]       fill_reg;
    logic [3:0]       fill_next;
    logic [7:0][7:0]  dly_reg;
    logic [7:0][7:0]  dly_next;
    logic [7:0][7:0]  dly_shift;
    logic [63:0]      h_cur;
    logic [63:0]      h_x;
    logic [63:0]      h_mul;
    logic             body;
    logic             acc;

    assign cfg.ready   = 1'b1;
    assign frame.ready = !q_full;
    assign acc         = frame.valid && frame.ready;
    assign body        = fill_reg[3];

    always_comb
    begin
        h_cur = (fill_reg == 4'd0) ? seed_reg : hash_reg;
        h_x   = h_cur ^ {56'd0, dly_reg[0]};
        h_mul = (h_x << 40) + (h_x << 8) + (h_x << 7) + (h_x << 5)
              + (h_x << 4) + (h_x << 1) + h_x;
        hash_next = body ? h_mul : h_cur;

        dly_shift = {frame.frame_byte, dly_reg[7:1]};
        dly_next  = dly_reg;
        if (body)
        begin
            dly_next = dly_shift;
        end
        else
        begin
            dly_next[fill_reg[2:0]] = frame.frame_byte;
        end
        fill_next = body ? fill_reg : fill_reg + 4'd1;

        ev.body        = body;
        ev.data        = dly_reg[0];
        ev.last        = frame.frame_end;
        ev.short_frame = !body && (fill_reg < 4'd7);
        ev.csum_bad    = (dly_next != hash_next);
        ev_push        = acc && (body || frame.frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= HASH_SEED_RST;
            hash_reg <= HASH_SEED_RST;
            fill_reg <= 4'd0;
            dly_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                seed_reg <= cfg.hash_seed;
            end
            if (acc)
            begin
                if (frame.frame_end)
                begin
                    fill_reg <= 4'd0;
                    dly_reg  <= '0;
                    hash_reg <= seed_reg;
                end
                else
                begin
                    fill_reg <= fill_next;
                    dly_reg  <= dly_next;
                    hash_reg <= hash_next;
                end
            end
        end
    end

endmodule

// ===== rtl/bfcp_queue.sv =====
`include "batch_frame_checker_parser_top_assert.svh"
// Short FIFO of classified beats between front and back.
// Depends on bfcp_pkg and the assertion macro header.
module bfcp_queue
    import bfcp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  ev_t  push_data,
    input  logic push,
    output logic full,
    output ev_t  pop_data,
    output logic pop_valid,
    input  logic pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ev_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `BFCP_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(DEPTH))
    `BFCP_ASSERT(a_no_overflow, clk, rst_n, !(push && full))
    `BFCP_ASSERT(a_no_underflow, clk, rst_n, !(pop && !pop_valid))
    `BFCP_ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

// ===== rtl/bfcp_back.sv =====
// Back end: section parser, element results, frame verdict, output register.
// Depends on bfcp_pkg and bfcp_if.
module bfcp_back
    import bfcp_pkg::*;
#(
    parameter int unsigned MAX_TOKENS  = MAX_TOKENS_DEF,
    parameter int unsigned MAX_SEQ_IDS = MAX_SEQ_IDS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  ev_t            ev,
    input  logic           ev_valid,
    output logic           ev_pop,
    bfcp_result_if.source  result
);

    localparam int unsigned CMAX  = (MAX_TOKENS > MAX_SEQ_IDS) ? MAX_TOKENS : MAX_SEQ_IDS;
    localparam int unsigned CW0   = $clog2(CMAX + 1);
    localparam int unsigned CNT_W = (CW0 < 5) ? 5 : CW0;
    localparam int unsigned SUM_W = $clog2(MAX_SEQ_IDS + 2);

    typedef enum logic [2:0] {
        SEC_HEADER, SEC_TOKENS, SEC_POS, SEC_COUNTS,
        SEC_IDS, SEC_LOGITS, SEC_DONE, SEC_STOPPED
    } section_t;

    section_t          sec_reg, sec_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0][7:0]   wb_reg, wb_next;
    logic [1:0]        biw_reg, biw_next;
    logic [15:0][7:0]  hdr_reg, hdr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              neg_reg, neg_next;
    logic [3:0]        err_reg, err_next;
    logic              out_valid_reg;
    res_t              out_reg, res;

    logic              got;
    logic [2:0]        kind;
    logic [CNT_W-1:0]  idx;
    logic [31:0]       val;
    logic [31:0]       word;
    logic [31:0]       limit;
    logic [32:0]       sum_wide;
    logic [31:0]       nt;
    logic [31:0]       ns;
    logic              hdr_bad;
    logic              hdr_ok;
    logic [3:0]        status;

    function automatic section_t next_after(section_t s, logic [7:0] p);
        section_t r;
        if (s < SEC_POS && p[PRESENT_POS])
            r = SEC_POS;
        else if (s < SEC_COUNTS && p[PRESENT_SEQ])
            r = SEC_COUNTS;
        else if (s < SEC_LOGITS && p[PRESENT_LOG])
            r = SEC_LOGITS;
        else
            r = SEC_DONE;
        return r;
    endfunction

    assign ev_pop = ev_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        sec_next = sec_reg;
        cnt_next = cnt_reg;
        wb_next  = wb_reg;
        biw_next = biw_reg;
        hdr_next = hdr_reg;
        sum_next = sum_reg;
        neg_next = neg_reg;
        err_next = err_reg;
        got      = 1'b0;
        kind     = EK_TOKEN;
        idx      = '0;
        val      = '0;
        word     = {ev.data, wb_reg};
        limit    = (sec_reg == SEC_IDS) ? hdr_reg[15:12] : hdr_reg[11:8];
        sum_wide = 33'(sum_reg) + {1'b0, word};

        hdr_next[cnt_reg[3:0]] = (ev.body && sec_reg == SEC_HEADER) ?
                                 ev.data : hdr_reg[cnt_reg[3:0]];
        nt = hdr_next[11:8];
        ns = hdr_next[15:12];
        hdr_bad = (hdr_next[7:6] != 16'd0) || (hdr_next[4] > 8'd1)
               || (hdr_next[5] > PRESENT_MAX) || nt[31] || (nt == 32'd0)
               || (nt > 32'(MAX_TOKENS)) || ns[31] || (ns > 32'(MAX_SEQ_IDS));

        if (ev.body)
        begin
            case (sec_reg)
                SEC_HEADER:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[3:0] == 4'd15)
                    begin
                        if (hdr_bad)
                        begin
                            err_next = ST_BAD_HEADER;
                            sec_next = SEC_STOPPED;
                        end
                        else
                        begin
                            sec_next = SEC_TOKENS;
                            cnt_next = '0;
                        end
                    end
                end
                SEC_DONE:
                begin
                    err_next = ST_TRAILING;
                    sec_next = SEC_STOPPED;
                end
                SEC_LOGITS:
                begin
                    got  = 1'b1;
                    kind = EK_LOGIT;
                    idx  = cnt_reg;
                    val  = {{24{ev.data[7]}}, ev.data};
                    cnt_next = cnt_reg + 1'b1;
                    if (32'(cnt_next) >= hdr_reg[11:8])
                    begin
                        sec_next = SEC_DONE;
                        cnt_next = '0;
                    end
                end
                SEC_TOKENS, SEC_POS, SEC_COUNTS, SEC_IDS:
                begin
                    if (biw_reg != 2'd3)
                    begin
                        wb_next[biw_reg] = ev.data;
                        biw_next = biw_reg + 2'd1;
                    end
                    else
                    begin
                        got  = 1'b1;
                        kind = 3'(sec_reg) - 3'd1;
                        idx  = cnt_reg;
                        val  = word;
                        wb_next  = '0;
                        biw_next = 2'd0;
                        if (sec_reg == SEC_COUNTS)
                        begin
                            if (word[31])
                                neg_next = 1'b1;
                            else if (sum_wide > 33'(MAX_SEQ_IDS + 1))
                                sum_next = SUM_W'(MAX_SEQ_IDS + 1);
                            else
                                sum_next = SUM_W'(sum_wide);
                        end
                        cnt_next = cnt_reg + 1'b1;
                        if (32'(cnt_next) >= limit)
                        begin
                            cnt_next = '0;
                            if (sec_reg == SEC_COUNTS)
                            begin
                                if (neg_next)
                                begin
                                    err_next = ST_NEGATIVE;
                                    sec_next = SEC_STOPPED;
                                end
                                else if (32'(sum_next) != hdr_reg[15:12])
                                begin
                                    err_next = ST_SUM;
                                    sec_next = SEC_STOPPED;
                                end
                                else if (hdr_reg[15:12] != 32'd0)
                                    sec_next = SEC_IDS;
                                else
                                    sec_next = next_after(SEC_IDS, hdr_reg[5]);
                            end
                            else
                            begin
                                sec_next = next_after(sec_reg, hdr_reg[5]);
                            end
                        end
                    end
                end
                default:
                begin
                    sec_next = sec_reg;
                end
            endcase
        end

        // verdict precedence: short, checksum, first error, open section
        if (ev.short_frame)
            status = ST_SHORT;
        else if (ev.csum_bad)
            status = ST_CHECKSUM;
        else if (err_next != 4'd0)
            status = err_next;
        else
        begin
            case (sec_next)
                SEC_HEADER: status = ST_TRUNC_HDR;
                SEC_TOKENS: status = ST_TRUNC_TOK;
                SEC_POS:    status = ST_TRUNC_POS;
                SEC_COUNTS: status = ST_TRUNC_CNT;
                SEC_IDS:    status = ST_TRUNC_IDS;
                SEC_LOGITS: status = ST_TRUNC_LOG;
                default:    status = ST_OK;
            endcase
        end
        hdr_ok = (sec_next != SEC_HEADER) && (err_next != ST_BAD_HEADER);

        res               = '0;
        res.elem_kind     = got ? kind : EK_TOKEN;
        res.elem_index    = 16'(idx);
        res.elem_value    = val;
        if (ev.last)
        begin
            res.is_verdict = 1'b1;
            res.status     = status;
            if (hdr_ok)
            begin
                res.seq_number    = hdr_next[3:0];
                res.encode_kind   = (hdr_next[4] == 8'd1);
                res.has_positions = hdr_next[5][PRESENT_POS];
                res.has_sequences = hdr_next[5][PRESENT_SEQ];
                res.has_logits    = hdr_next[5][PRESENT_LOG];
                res.token_count   = 13'(hdr_next[9:8]);
                res.seq_id_total  = 17'(hdr_next[15:12]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= SEC_HEADER;
            cnt_reg       <= '0;
            wb_reg        <= '0;
            biw_reg       <= '0;
            hdr_reg       <= '0;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            err_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_pop)
            begin
                if (ev.last)
                begin
                    sec_reg <= SEC_HEADER;
                    cnt_reg <= '0;
                    wb_reg  <= '0;
                    biw_reg <= '0;
                    hdr_reg <= '0;
                    sum_reg <= '0;
                    neg_reg <= 1'b0;
                    err_reg <= 4'd0;
                end
                else
                begin
                    sec_reg <= sec_next;
                    cnt_reg <= cnt_next;
                    wb_reg  <= wb_next;
                    biw_reg <= biw_next;
                    hdr_reg <= hdr_next;
                    sum_reg <= sum_next;
                    neg_reg <= neg_next;
                    err_reg <= err_next;
                end
                out_valid_reg <= got || ev.last;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            out_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.is_verdict    = out_reg.is_verdict;
    assign result.status        = out_reg.status;
    assign result.elem_kind     = out_reg.elem_kind;
    assign result.elem_index    = out_reg.elem_index;
    assign result.elem_value    = out_reg.elem_value;
    assign result.seq_number    = out_reg.seq_number;
    assign result.encode_kind   = out_reg.encode_kind;
    assign result.has_positions = out_reg.has_positions;
    assign result.has_sequences = out_reg.has_sequences;
    assign result.has_logits    = out_reg.has_logits;
    assign result.token_count   = out_reg.token_count;
    assign result.seq_id_total  = out_reg.seq_id_total;

endmodule

// ===== rtl/batch_frame_checker_parser_top.sv =====
// Path: a beat is queued, then its result is held in the output register
// (a body byte reaches the parser when the eighth byte after it arrives).
// Throughput: one frame byte per cycle unless the queue is full; the hash
// shift-add chain sets the clock. Reset: all frame state clears, the seed
// returns to the FNV-64 offset basis; no clearing pass precedes the first byte.
// Depends on bfcp_pkg, bfcp_if, bfcp_front, bfcp_queue, bfcp_back.
module batch_frame_checker_parser_top
    import bfcp_pkg::*;
#(
    parameter int unsigned MAX_TOKENS  = MAX_TOKENS_DEF,
    parameter int unsigned MAX_SEQ_IDS = MAX_SEQ_IDS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    bfcp_cfg_if.sink      cfg,
    bfcp_frame_if.sink    frame,
    bfcp_result_if.source result
);

    ev_t  ev_in;
    ev_t  ev_out;
    logic ev_push;
    logic q_full;
    logic ev_valid;
    logic ev_pop;

    bfcp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .frame   (frame),
        .ev      (ev_in),
        .ev_push (ev_push),
        .q_full  (q_full)
    );

    bfcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (ev_in),
        .push      (ev_push),
        .full      (q_full),
        .pop_data  (ev_out),
        .pop_valid (ev_valid),
        .pop       (ev_pop)
    );

    bfcp_back #(
        .MAX_TOKENS  (MAX_TOKENS),
        .MAX_SEQ_IDS (MAX_SEQ_IDS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev_out),
        .ev_valid (ev_valid),
        .ev_pop   (ev_pop),
        .result   (result)
    );

endmodule
